@@ src/cedge_pkg.sv @@
// shared constants, codes and controller/datapath interface types for the edge detector
`timescale 1ns / 1ps
package cedge_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    // configuration port
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STRONG_LEVEL = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WEAK_LEVEL   = 2'd3;
    localparam logic [CFG_W-1:0] RST_FRAME_WIDTH  = 11'd1024;
    localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = 11'd1024;
    localparam logic [CFG_W-1:0] RST_STRONG_LEVEL = 11'd170;
    localparam logic [CFG_W-1:0] RST_WEAK_LEVEL   = 11'd85;

    // data widths
    localparam int COLOR_W = 8;
    localparam int GRAY_W  = 8;
    localparam int MAG_W   = 11;
    localparam int SEC_W   = 2;
    localparam int GRAD_W  = 12;
    localparam int SQ_W    = 22;
    localparam int POS_W   = 10;

    // slope thresholds in unsigned q13
    localparam int TAN_LO    = 3393;
    localparam int TAN_HI    = 19777;
    localparam int Q13_SHIFT = 13;
    localparam int PROD_W    = 25;

    // gradient sectors
    localparam logic [SEC_W-1:0] SEC_HORZ = 2'd0;
    localparam logic [SEC_W-1:0] SEC_RISE = 2'd1;
    localparam logic [SEC_W-1:0] SEC_VERT = 2'd2;
    localparam logic [SEC_W-1:0] SEC_FALL = 2'd3;

    // 3x3 window, fetched in raster order
    localparam int WIN_N   = 9;
    localparam int WIN_K_W = 4;
    localparam logic [WIN_K_W-1:0] WIN_LAST_K = 4'd8;

    typedef struct packed {
        logic               take;
        logic               calc_total;
        logic               gray_wr;
        logic               fetch_go;
        logic [WIN_K_W-1:0] fetch_k;
        logic               fetch_mag;
        logic               sobel;
        logic               square;
        logic               root_start;
        logic               mag_wr;
        logic               out_load;
    } cmd_t;

    typedef struct packed {
        logic do_grad;
        logic do_out;
        logic root_done;
        logic out_free;
    } stat_t;

endpackage

@@ src/cedge_sqrt.sv @@
// iterative integer square root, two radicand bits per cycle
`timescale 1ns / 1ps
module cedge_sqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [cedge_pkg::SQ_W-1:0]  value,
    output logic                        done,
    output logic [cedge_pkg::MAG_W-1:0] root
);

    localparam int STEPS = cedge_pkg::SQ_W / 2;
    localparam int CNT_W = $clog2(STEPS + 1);
    localparam int REM_W = cedge_pkg::MAG_W + 2;
    localparam int CUR_W = REM_W + 2;

    logic                        busy_reg;
    logic                        done_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic [cedge_pkg::SQ_W-1:0]  val_reg;
    logic [REM_W-1:0]            rem_reg;
    logic [cedge_pkg::MAG_W-1:0] root_reg;

    logic [CUR_W-1:0] cur;
    logic [CUR_W-1:0] trial;

    always_comb
    begin
        cur   = {rem_reg, val_reg[cedge_pkg::SQ_W-1 -: 2]};
        trial = {2'b00, root_reg, 2'b01};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(STEPS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            val_reg  <= value;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            val_reg <= val_reg << 2;
            if (cur >= trial)
            begin
                rem_reg  <= REM_W'(cur - trial);
                root_reg <= {root_reg[cedge_pkg::MAG_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= REM_W'(cur);
                root_reg <= {root_reg[cedge_pkg::MAG_W-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

@@ src/cedge_dp.sv @@
// datapath: config registers, counters, line memories, sobel, sector, edge and output register
`timescale 1ns / 1ps
module cedge_dp #(
    parameter int MAX_WIDTH  = cedge_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = cedge_pkg::DEF_MAX_HEIGHT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  cedge_pkg::cmd_t                 cmd,
    output cedge_pkg::stat_t                stat,
    input  logic [cedge_pkg::COLOR_W-1:0]   blue,
    input  logic [cedge_pkg::COLOR_W-1:0]   green,
    input  logic [cedge_pkg::COLOR_W-1:0]   red,
    input  logic                            flush,
    input  logic                            cfg_we,
    input  logic [cedge_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  logic [cedge_pkg::CFG_W-1:0]     cfg_data,
    input  logic                            out_ready,
    output logic                            out_valid,
    output logic                            edge_res,
    output logic [cedge_pkg::POS_W-1:0]     out_row,
    output logic [cedge_pkg::POS_W-1:0]     out_col,
    output logic                            last_of_frame
);

    localparam int CW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int CLW   = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int AW    = $clog2(2 * MAX_WIDTH + 4);
    localparam int DEPTH = 1 << AW;
    localparam int TW    = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int PW    = $clog2(MAX_WIDTH * MAX_HEIGHT + 2 * MAX_WIDTH + 3);
    localparam int MW    = cedge_pkg::MAG_W;
    localparam int GW    = cedge_pkg::GRAD_W;
    localparam int SUM_W = cedge_pkg::COLOR_W + 2;
    localparam int DIV_W = 2 * SUM_W;
    // floor(s/3) == (s*683)>>11 for every s below 2048
    localparam int RECIP3     = 683;
    localparam int RECIP3_SHR = 11;

    // configuration
    logic [cedge_pkg::CFG_W-1:0] frame_width_reg, frame_height_reg;
    logic [cedge_pkg::CFG_W-1:0] strong_level_reg, weak_level_reg;

    // frame geometry and counters
    logic [CW-1:0]  cur_w_reg;
    logic [HW-1:0]  cur_h_reg;
    logic [TW-1:0]  total_reg;
    logic [PW-1:0]  p_reg;
    logic           do_grad_reg, do_out_reg;
    logic [AW-1:0]  gaddr_reg, oaddr_reg;
    logic [RW-1:0]  grow_reg, orow_reg;
    logic [CLW-1:0] gcol_reg, ocol_reg;
    logic [TW-1:0]  ot_reg;

    logic [cedge_pkg::GRAY_W-1:0] gray_in_reg;

    // line memories
    logic [cedge_pkg::GRAY_W-1:0] gray_mem [DEPTH];
    logic [MW-1:0]                mag_mem  [DEPTH];
    logic [cedge_pkg::SEC_W-1:0]  sec_mem  [DEPTH];
    logic [cedge_pkg::GRAY_W-1:0] gray_q;
    logic [MW-1:0]                mag_q;
    logic [cedge_pkg::SEC_W-1:0]  sec_q;

    // window fetch
    logic                          rd_live_reg, rd_in_reg, rd_mag_reg;
    logic [cedge_pkg::WIN_K_W-1:0] rd_k_reg;
    logic [MW-1:0]                 win_reg [cedge_pkg::WIN_N];
    logic [cedge_pkg::WIN_N-1:0]   winv_reg;
    logic [cedge_pkg::SEC_W-1:0]   cen_sec_reg;

    // gradient
    logic signed [GW-1:0]           gx_reg, gy_reg;
    logic [cedge_pkg::SQ_W-1:0]     sq_reg;
    logic [cedge_pkg::PROD_W-1:0]   lo_reg, hi_reg, yy_reg;
    logic                           xneg_reg, yzero_reg;
    logic [cedge_pkg::SEC_W-1:0]    sec_reg;
    logic                           root_done;
    logic [MW-1:0]                  root;

    // output register
    logic                       out_valid_reg, edge_out_reg, last_out_reg;
    logic [cedge_pkg::POS_W-1:0] row_out_reg, col_out_reg;

    // combinational
    logic [CW-1:0]        w_clamp;
    logic [HW-1:0]        h_clamp;
    logic [SUM_W-1:0]     csum;
    logic [DIV_W-1:0]     cprod;
    logic [PW-1:0]        w1, lim, p_total;
    logic [AW-1:0]        center, roff, coff, raddr, wa;
    logic [RW-1:0]        crow;
    logic [CLW-1:0]       ccol;
    logic [1:0]           rsel, csel;
    logic                 rin, cin;
    logic signed [GW-1:0] g [cedge_pkg::WIN_N];
    logic signed [GW-1:0] gx, gy, ax, ay;
    logic signed [2*GW-1:0] sqx, sqy;
    logic [MW-1:0]        mag, ac0, ac1, al0, al1;
    logic                 acv0, acv1, alv0, alv1;
    logic                 edge_val, last;
    logic [cedge_pkg::SEC_W-1:0] sec_calc;

    function automatic logic [1:0] win_row(input logic [cedge_pkg::WIN_K_W-1:0] k);
        case (k)
            4'd0, 4'd1, 4'd2: win_row = 2'd0;
            4'd6, 4'd7, 4'd8: win_row = 2'd2;
            default:          win_row = 2'd1;
        endcase
    endfunction

    function automatic logic [1:0] win_col(input logic [cedge_pkg::WIN_K_W-1:0] k);
        case (k)
            4'd0, 4'd3, 4'd6: win_col = 2'd0;
            4'd2, 4'd5, 4'd8: win_col = 2'd2;
            default:          win_col = 2'd1;
        endcase
    endfunction

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= cedge_pkg::RST_FRAME_WIDTH;
            frame_height_reg <= cedge_pkg::RST_FRAME_HEIGHT;
            strong_level_reg <= cedge_pkg::RST_STRONG_LEVEL;
            weak_level_reg   <= cedge_pkg::RST_WEAK_LEVEL;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                cedge_pkg::REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                cedge_pkg::REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                cedge_pkg::REG_STRONG_LEVEL: strong_level_reg <= cfg_data;
                cedge_pkg::REG_WEAK_LEVEL:   weak_level_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (frame_width_reg == '0)
            w_clamp = CW'(1);
        else if (32'(frame_width_reg) > 32'(MAX_WIDTH))
            w_clamp = CW'(MAX_WIDTH);
        else
            w_clamp = CW'(frame_width_reg);

        if (frame_height_reg == '0)
            h_clamp = HW'(1);
        else if (32'(frame_height_reg) > 32'(MAX_HEIGHT))
            h_clamp = HW'(MAX_HEIGHT);
        else
            h_clamp = HW'(frame_height_reg);

        csum  = SUM_W'(blue) + SUM_W'(green) + SUM_W'(red);
        cprod = DIV_W'(csum) * DIV_W'(RECIP3);

        w1      = PW'(cur_w_reg) + PW'(1);
        p_total = PW'(total_reg);
        lim     = p_total + w1;
    end

    // geometry, slot counter and decisions for the current beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_w_reg   <= CW'(cedge_pkg::RST_FRAME_WIDTH);
            cur_h_reg   <= HW'(cedge_pkg::RST_FRAME_HEIGHT);
            p_reg       <= '0;
            do_grad_reg <= 1'b0;
            do_out_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.take && p_reg == '0)
            begin
                cur_w_reg <= w_clamp;
                cur_h_reg <= h_clamp;
            end
            if (cmd.gray_wr)
            begin
                do_grad_reg <= (p_reg >= w1) && (p_reg < lim);
                do_out_reg  <= (p_reg >= (w1 << 1));
                p_reg       <= p_reg + PW'(1);
            end
            else if (cmd.out_load && last)
                p_reg <= '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
            gray_in_reg <= flush ? '0 :
                cedge_pkg::GRAY_W'(cprod[RECIP3_SHR +: cedge_pkg::GRAY_W]);
        if (cmd.calc_total)
            total_reg <= TW'(TW'(cur_w_reg) * TW'(cur_h_reg));
    end

    // window addressing around the selected center
    always_comb
    begin
        center = cmd.fetch_mag ? oaddr_reg : gaddr_reg;
        crow   = cmd.fetch_mag ? orow_reg : grow_reg;
        ccol   = cmd.fetch_mag ? ocol_reg : gcol_reg;
        wa     = AW'(cur_w_reg);
        rsel   = win_row(cmd.fetch_k);
        csel   = win_col(cmd.fetch_k);
        case (rsel)
            2'd0:    roff = AW'(0) - wa;
            2'd2:    roff = wa;
            default: roff = '0;
        endcase
        case (csel)
            2'd0:    coff = '1;
            2'd2:    coff = AW'(1);
            default: coff = '0;
        endcase
        raddr = center + roff + coff;
        case (rsel)
            2'd0:    rin = (crow != '0);
            2'd2:    rin = ((HW+1)'(crow) + (HW+1)'(1)) < (HW+1)'(cur_h_reg);
            default: rin = 1'b1;
        endcase
        case (csel)
            2'd0:    cin = (ccol != '0);
            2'd2:    cin = ((CW+1)'(ccol) + (CW+1)'(1)) < (CW+1)'(cur_w_reg);
            default: cin = 1'b1;
        endcase
    end

    // line memories
    always_ff @(posedge clk)
    begin
        if (cmd.gray_wr && p_reg < p_total)
            gray_mem[p_reg[AW-1:0]] <= gray_in_reg;
        if (cmd.mag_wr)
        begin
            mag_mem[gaddr_reg] <= root;
            sec_mem[gaddr_reg] <= sec_reg;
        end
        if (cmd.fetch_go)
        begin
            gray_q <= gray_mem[raddr];
            mag_q  <= mag_mem[raddr];
            sec_q  <= sec_mem[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rd_live_reg <= 1'b0;
        else
            rd_live_reg <= cmd.fetch_go;
    end

    always_ff @(posedge clk)
    begin
        rd_k_reg   <= cmd.fetch_k;
        rd_in_reg  <= rin && cin;
        rd_mag_reg <= cmd.fetch_mag;
        if (rd_live_reg)
        begin
            // pixels outside the frame read as zero
            if (!rd_in_reg)
                win_reg[rd_k_reg] <= '0;
            else if (rd_mag_reg)
                win_reg[rd_k_reg] <= mag_q;
            else
                win_reg[rd_k_reg] <= MW'(gray_q);
            winv_reg[rd_k_reg] <= rd_in_reg;
            if (rd_mag_reg && rd_k_reg == cedge_pkg::WIN_K_W'(4))
                cen_sec_reg <= sec_q;
        end
    end

    // sobel and sector
    always_comb
    begin
        for (int i = 0; i < cedge_pkg::WIN_N; i++)
            g[i] = $signed({{(GW-cedge_pkg::GRAY_W){1'b0}}, win_reg[i][cedge_pkg::GRAY_W-1:0]});
        gx = g[2] - g[0] + (g[5] <<< 1) - (g[3] <<< 1) + g[8] - g[6];
        gy = g[0] + (g[1] <<< 1) + g[2] - g[6] - (g[7] <<< 1) - g[8];
        ax  = (gx_reg < 0) ? -gx_reg : gx_reg;
        ay  = (gy_reg < 0) ? -gy_reg : gy_reg;
        sqx = gx_reg * gx_reg;
        sqy = gy_reg * gy_reg;

        // on a boundary the larger angle wins
        if (yzero_reg)
            sec_calc = cedge_pkg::SEC_HORZ;
        else if (!xneg_reg)
        begin
            if (yy_reg < lo_reg)
                sec_calc = cedge_pkg::SEC_HORZ;
            else if (yy_reg >= hi_reg)
                sec_calc = cedge_pkg::SEC_VERT;
            else
                sec_calc = cedge_pkg::SEC_RISE;
        end
        else
        begin
            if (yy_reg <= lo_reg)
                sec_calc = cedge_pkg::SEC_HORZ;
            else if (yy_reg > hi_reg)
                sec_calc = cedge_pkg::SEC_VERT;
            else
                sec_calc = cedge_pkg::SEC_FALL;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sobel)
        begin
            gx_reg <= gx;
            gy_reg <= gy;
        end
        if (cmd.square)
        begin
            sq_reg    <= cedge_pkg::SQ_W'(sqx + sqy);
            lo_reg    <= cedge_pkg::PROD_W'(ax) * cedge_pkg::PROD_W'(cedge_pkg::TAN_LO);
            hi_reg    <= cedge_pkg::PROD_W'(ax) * cedge_pkg::PROD_W'(cedge_pkg::TAN_HI);
            yy_reg    <= cedge_pkg::PROD_W'(ay) << cedge_pkg::Q13_SHIFT;
            // fold into the upper half plane
            xneg_reg  <= (gy_reg < 0) ? (gx_reg > 0) : (gx_reg < 0);
            yzero_reg <= (gy_reg == '0);
        end
        if (cmd.root_start)
            sec_reg <= sec_calc;
    end

    cedge_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.root_start),
        .value (sq_reg),
        .done  (root_done),
        .root  (root)
    );

    // hysteresis and non-maximum suppression
    always_comb
    begin
        mag = win_reg[4];
        case (cen_sec_reg)
            cedge_pkg::SEC_HORZ:
            begin
                ac0 = win_reg[1]; acv0 = winv_reg[1]; ac1 = win_reg[7]; acv1 = winv_reg[7];
                al0 = win_reg[5]; alv0 = winv_reg[5]; al1 = win_reg[3]; alv1 = winv_reg[3];
            end
            cedge_pkg::SEC_RISE:
            begin
                ac0 = win_reg[0]; acv0 = winv_reg[0]; ac1 = win_reg[8]; acv1 = winv_reg[8];
                al0 = win_reg[2]; alv0 = winv_reg[2]; al1 = win_reg[6]; alv1 = winv_reg[6];
            end
            cedge_pkg::SEC_VERT:
            begin
                ac0 = win_reg[5]; acv0 = winv_reg[5]; ac1 = win_reg[3]; acv1 = winv_reg[3];
                al0 = win_reg[1]; alv0 = winv_reg[1]; al1 = win_reg[7]; alv1 = winv_reg[7];
            end
            default:
            begin
                ac0 = win_reg[2]; acv0 = winv_reg[2]; ac1 = win_reg[6]; acv1 = winv_reg[6];
                al0 = win_reg[0]; alv0 = winv_reg[0]; al1 = win_reg[8]; alv1 = winv_reg[8];
            end
        endcase
        if (mag >= strong_level_reg)
            edge_val = 1'b1;
        else if (mag >= weak_level_reg)
            edge_val = (acv0 && ac0 >= strong_level_reg) || (acv1 && ac1 >= strong_level_reg);
        else
            edge_val = 1'b0;
        if ((alv0 && al0 > mag) || (alv1 && al1 > mag))
            edge_val = 1'b0;

        last = ((TW+1)'(ot_reg) + (TW+1)'(1)) >= (TW+1)'(total_reg);
    end

    // gradient and output position counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gaddr_reg <= '0;
            grow_reg  <= '0;
            gcol_reg  <= '0;
            oaddr_reg <= '0;
            orow_reg  <= '0;
            ocol_reg  <= '0;
            ot_reg    <= '0;
        end
        else if (cmd.mag_wr)
        begin
            gaddr_reg <= gaddr_reg + AW'(1);
            if ((CW+1)'(gcol_reg) + (CW+1)'(1) >= (CW+1)'(cur_w_reg))
            begin
                gcol_reg <= '0;
                grow_reg <= grow_reg + RW'(1);
            end
            else
                gcol_reg <= gcol_reg + CLW'(1);
        end
        else if (cmd.out_load)
        begin
            if (last)
            begin
                gaddr_reg <= '0;
                grow_reg  <= '0;
                gcol_reg  <= '0;
                oaddr_reg <= '0;
                orow_reg  <= '0;
                ocol_reg  <= '0;
                ot_reg    <= '0;
            end
            else
            begin
                oaddr_reg <= oaddr_reg + AW'(1);
                ot_reg    <= ot_reg + TW'(1);
                if ((CW+1)'(ocol_reg) + (CW+1)'(1) >= (CW+1)'(cur_w_reg))
                begin
                    ocol_reg <= '0;
                    orow_reg <= orow_reg + RW'(1);
                end
                else
                    ocol_reg <= ocol_reg + CLW'(1);
            end
        end
    end

    // output beat register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            edge_out_reg <= edge_val;
            row_out_reg  <= cedge_pkg::POS_W'(orow_reg);
            col_out_reg  <= cedge_pkg::POS_W'(ocol_reg);
            last_out_reg <= last;
        end
    end

    always_comb
    begin
        stat.do_grad   = do_grad_reg;
        stat.do_out    = do_out_reg;
        stat.root_done = root_done;
        stat.out_free  = !out_valid_reg || out_ready;
    end

    assign out_valid     = out_valid_reg;
    assign edge_res      = edge_out_reg;
    assign out_row       = row_out_reg;
    assign out_col       = col_out_reg;
    assign last_of_frame = last_out_reg;

endmodule

@@ src/cedge_ctrl.sv @@
// controller state machine sequencing one beat through the datapath
`timescale 1ns / 1ps
module cedge_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output cedge_pkg::cmd_t  cmd,
    input  cedge_pkg::stat_t stat
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_TOT    = 4'd1;
    localparam logic [3:0] S_FLAG   = 4'd2;
    localparam logic [3:0] S_DEC    = 4'd3;
    localparam logic [3:0] S_GFETCH = 4'd4;
    localparam logic [3:0] S_GWAIT  = 4'd5;
    localparam logic [3:0] S_SOB    = 4'd6;
    localparam logic [3:0] S_SQ     = 4'd7;
    localparam logic [3:0] S_ROOT0  = 4'd8;
    localparam logic [3:0] S_ROOT   = 4'd9;
    localparam logic [3:0] S_MWR    = 4'd10;
    localparam logic [3:0] S_EFETCH = 4'd11;
    localparam logic [3:0] S_EWAIT  = 4'd12;
    localparam logic [3:0] S_OUT    = 4'd13;

    logic [3:0]                    state_reg, state_next;
    logic [cedge_pkg::WIN_K_W-1:0] k_reg, k_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = S_TOT;
                end
            end
            S_TOT:
            begin
                cmd.calc_total = 1'b1;
                state_next     = S_FLAG;
            end
            S_FLAG:
            begin
                cmd.gray_wr = 1'b1;
                state_next  = S_DEC;
            end
            S_DEC:
            begin
                k_next = '0;
                if (stat.do_grad)
                    state_next = S_GFETCH;
                else if (stat.do_out)
                    state_next = S_EFETCH;
                else
                    state_next = S_IDLE;
            end
            S_GFETCH:
            begin
                cmd.fetch_go = 1'b1;
                cmd.fetch_k  = k_reg;
                if (k_reg == cedge_pkg::WIN_LAST_K)
                    state_next = S_GWAIT;
                else
                    k_next = k_reg + cedge_pkg::WIN_K_W'(1);
            end
            S_GWAIT:
                state_next = S_SOB;
            S_SOB:
            begin
                cmd.sobel  = 1'b1;
                state_next = S_SQ;
            end
            S_SQ:
            begin
                cmd.square = 1'b1;
                state_next = S_ROOT0;
            end
            S_ROOT0:
            begin
                cmd.root_start = 1'b1;
                state_next     = S_ROOT;
            end
            S_ROOT:
            begin
                if (stat.root_done)
                    state_next = S_MWR;
            end
            S_MWR:
            begin
                cmd.mag_wr = 1'b1;
                k_next     = '0;
                state_next = stat.do_out ? S_EFETCH : S_IDLE;
            end
            S_EFETCH:
            begin
                cmd.fetch_go  = 1'b1;
                cmd.fetch_k   = k_reg;
                cmd.fetch_mag = 1'b1;
                if (k_reg == cedge_pkg::WIN_LAST_K)
                    state_next = S_EWAIT;
                else
                    k_next = k_reg + cedge_pkg::WIN_K_W'(1);
            end
            S_EWAIT:
                state_next = S_OUT;
            S_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    a_load_into_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> stat.out_free)
        else $error("result loaded over an untaken beat");

    a_one_beat_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second beat taken while one is in work");

    a_root_then_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROOT && stat.root_done) |=> cmd.mag_wr)
        else $error("magnitude not written after root finished");

endmodule

@@ src/canny_edge_pixel_stream.sv @@
// top level: canny edge detector on a raster pixel stream
//
//  channel  direction  handshake             payload
//  input    in         in_valid / in_ready   blue, green, red, flush
//  output   out        out_valid / out_ready edge_res, out_row, out_col, last_of_frame
//  config   in         cfg_we                cfg_idx, cfg_data
//
// one beat at a time; nine single-port line memory reads per 3x3 window (done twice)
// and the 11-step square root set how long a beat with gradient and result takes.
// reset needs no memory clearing pass; counters and the output register clear at once.
// a finished result waits in the output register while the next beat is taken;
// the block stalls only when a new result meets an untaken one.
`timescale 1ns / 1ps
module canny_edge_pixel_stream #(
    parameter int MAX_WIDTH  = cedge_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = cedge_pkg::DEF_MAX_HEIGHT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [cedge_pkg::COLOR_W-1:0]   blue,
    input  logic [cedge_pkg::COLOR_W-1:0]   green,
    input  logic [cedge_pkg::COLOR_W-1:0]   red,
    input  logic                            flush,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            edge_res,
    output logic [cedge_pkg::POS_W-1:0]     out_row,
    output logic [cedge_pkg::POS_W-1:0]     out_col,
    output logic                            last_of_frame,
    input  logic                            cfg_we,
    input  logic [cedge_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  logic [cedge_pkg::CFG_W-1:0]     cfg_data
);

    cedge_pkg::cmd_t  cmd;
    cedge_pkg::stat_t stat;

    cedge_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .stat     (stat)
    );

    cedge_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .blue          (blue),
        .green         (green),
        .red           (red),
        .flush         (flush),
        .cfg_we        (cfg_we),
        .cfg_idx       (cfg_idx),
        .cfg_data      (cfg_data),
        .out_ready     (out_ready),
        .out_valid     (out_valid),
        .edge_res      (edge_res),
        .out_row       (out_row),
        .out_col       (out_col),
        .last_of_frame (last_of_frame)
    );

endmodule

@@ tb/sv/canny_edge_pixel_stream_test.sv @@
// self-checking testbench for the canny edge detector pixel stream
`timescale 1ns / 1ps
module canny_edge_pixel_stream_test;

    localparam int RING     = 2 * cedge_pkg::DEF_MAX_WIDTH + 4;
    localparam int WATCHDOG = 20000;
    localparam int SETTLE   = 60;
    localparam int HOLD_LEN = 3000;

    // neighbor offsets (row, col) per sector
    localparam int ACROSS[4][2][2] = '{'{'{-1, 0}, '{1, 0}}, '{'{-1, -1}, '{1, 1}},
                                       '{'{0, 1}, '{0, -1}}, '{'{-1, 1}, '{1, -1}}};
    localparam int ALONG[4][2][2]  = '{'{'{0, 1}, '{0, -1}}, '{'{-1, 1}, '{1, -1}},
                                       '{'{-1, 0}, '{1, 0}}, '{'{-1, -1}, '{1, 1}}};

    typedef struct {
        bit           edge_res;
        bit [9:0]     row;
        bit [9:0]     col;
        bit           last;
    } pix_res_t;

    typedef struct {
        bit [7:0] b;
        bit [7:0] g;
        bit [7:0] r;
        bit       fl;
        bit       typed;
        pix_res_t want;
    } dir_row_t;

    logic                            clk;
    logic                            rst_n;
    logic                            in_valid;
    logic                            in_ready;
    logic [cedge_pkg::COLOR_W-1:0]   blue;
    logic [cedge_pkg::COLOR_W-1:0]   green;
    logic [cedge_pkg::COLOR_W-1:0]   red;
    logic                            flush;
    logic                            out_valid;
    logic                            out_ready;
    logic                            edge_res;
    logic [cedge_pkg::POS_W-1:0]     out_row;
    logic [cedge_pkg::POS_W-1:0]     out_col;
    logic                            last_of_frame;
    logic                            cfg_we;
    logic [cedge_pkg::CFG_IDX_W-1:0] cfg_idx;
    logic [cedge_pkg::CFG_W-1:0]     cfg_data;

    canny_edge_pixel_stream DUT (.*);

    // predictor state
    int  reg_width  = 1024;
    int  reg_height = 1024;
    int  reg_strong = 170;
    int  reg_weak   = 85;
    int  cur_w = 1024;
    int  cur_h = 1024;
    int  in_r, in_c, out_r, out_c;
    int  gray_ring [RING];
    int  mag_ring [RING];
    int  sec_ring [RING];

    pix_res_t pending_px[$];
    bit       failed;
    bit       calm;
    bit       hold_req;
    int       idle_cycles;
    int       beats_sent;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int clamp_size(int v);
        if (v < 1) return 1;
        if (v > 1024) return 1024;
        return v;
    endfunction

    function automatic bit on_frame(int r, int c);
        return r >= 0 && c >= 0 && r < cur_h && c < cur_w;
    endfunction

    function automatic int slot(int r, int c);
        return (r * cur_w + c) % RING;
    endfunction

    function automatic int gray_of(int r, int c);
        if (!on_frame(r, c)) return 0;
        return gray_ring[slot(r, c)];
    endfunction

    function automatic int root_floor(int v);
        int res;
        int b4;
        res = 0;
        b4 = 1 << 30;
        while (b4 > v) b4 >>= 2;
        while (b4 != 0) begin
            if (v >= res + b4) begin
                v -= res + b4;
                res = (res >> 1) + b4;
            end
            else res >>= 1;
            b4 >>= 2;
        end
        return res;
    endfunction

    function automatic int sector_of(int gx, int gy);
        int x, y, ax, lo, hi, yy;
        x = gx;
        y = gy;
        if (y < 0) begin
            x = -x;
            y = -y;
        end
        if (y == 0) return cedge_pkg::SEC_HORZ;
        ax = x < 0 ? -x : x;
        lo = cedge_pkg::TAN_LO * ax;
        hi = cedge_pkg::TAN_HI * ax;
        yy = (1 << cedge_pkg::Q13_SHIFT) * y;
        if (x >= 0) begin
            if (yy < lo) return cedge_pkg::SEC_HORZ;
            if (yy >= hi) return cedge_pkg::SEC_VERT;
            return cedge_pkg::SEC_RISE;
        end
        if (yy <= lo) return cedge_pkg::SEC_HORZ;
        if (yy > hi) return cedge_pkg::SEC_VERT;
        return cedge_pkg::SEC_FALL;
    endfunction

    function automatic void sobel_at(int r, int c);
        int gx, gy;
        gx = -gray_of(r-1, c-1) + gray_of(r-1, c+1) - 2*gray_of(r, c-1) + 2*gray_of(r, c+1)
             - gray_of(r+1, c-1) + gray_of(r+1, c+1);
        gy = gray_of(r-1, c-1) + 2*gray_of(r-1, c) + gray_of(r-1, c+1)
             - gray_of(r+1, c-1) - 2*gray_of(r+1, c) - gray_of(r+1, c+1);
        mag_ring[slot(r, c)] = root_floor(gx*gx + gy*gy) & 'h7FF;
        sec_ring[slot(r, c)] = sector_of(gx, gy);
    endfunction

    function automatic bit edge_decision(int r, int c);
        int  mag, sec, nr, nc;
        bit  e;
        mag = mag_ring[slot(r, c)];
        sec = sec_ring[slot(r, c)];
        e = 1'b0;
        if (mag >= reg_strong) e = 1'b1;
        else if (mag >= reg_weak) begin
            for (int k = 0; k < 2; k++) begin
                nr = r + ACROSS[sec][k][0];
                nc = c + ACROSS[sec][k][1];
                if (on_frame(nr, nc) && mag_ring[slot(nr, nc)] >= reg_strong) e = 1'b1;
            end
        end
        for (int k = 0; k < 2; k++) begin
            nr = r + ALONG[sec][k][0];
            nc = c + ALONG[sec][k][1];
            if (on_frame(nr, nc) && mag_ring[slot(nr, nc)] > mag) e = 1'b0;
        end
        return e;
    endfunction

    // advance the edge model by one beat; got is set when a pixel result falls out
    function automatic void model_beat(input bit [7:0] b, g, r, input bit fl,
                                       output bit got, output pix_res_t res);
        int total, w1, p, q;
        got = 1'b0;
        res = '{default: 0};
        if (in_r == 0 && in_c == 0) begin
            cur_w = clamp_size(reg_width);
            cur_h = clamp_size(reg_height);
        end
        total = cur_w * cur_h;
        w1 = cur_w + 1;
        p = in_r * cur_w + in_c;
        if (p < total) gray_ring[p % RING] = fl ? 0 : (int'(b) + int'(g) + int'(r)) / 3;
        if (p >= w1 && p - w1 < total) begin
            q = p - w1;
            sobel_at(q / cur_w, q % cur_w);
        end
        in_c++;
        if (in_c >= cur_w) begin
            in_c = 0;
            in_r++;
        end
        if (p >= 2 * w1) begin
            got = 1'b1;
            res.last = (out_r * cur_w + out_c + 1) >= total;
            res.edge_res = edge_decision(out_r, out_c);
            res.row = out_r[9:0];
            res.col = out_c[9:0];
            out_c++;
            if (out_c >= cur_w) begin
                out_c = 0;
                out_r++;
            end
            if (res.last) begin
                in_r = 0;
                in_c = 0;
                out_r = 0;
                out_c = 0;
            end
        end
    endfunction

    function automatic int gap_len();
        int d;
        if (calm) return 0;
        d = $urandom_range(99);
        if (d < 60) return 0;
        if (d < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic write_reg(input logic [cedge_pkg::CFG_IDX_W-1:0] idx, input int val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val[cedge_pkg::CFG_W-1:0];
        @(posedge clk);
        cfg_we   <= 1'b0;
        @(posedge clk);
        case (idx)
            cedge_pkg::REG_FRAME_WIDTH:  reg_width  = val & 'h7FF;
            cedge_pkg::REG_FRAME_HEIGHT: reg_height = val & 'h7FF;
            cedge_pkg::REG_STRONG_LEVEL: reg_strong = val & 'h7FF;
            default:                     reg_weak   = val & 'h7FF;
        endcase
    endtask

    // offer one beat, wait for it to be taken, then record what it should produce
    task automatic send_pixel(input bit [7:0] b, g, r, input bit fl, input bit typed,
                              input pix_res_t want);
        int       n;
        bit       got;
        pix_res_t res;
        n = gap_len();
        if (n > 0) begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        in_valid <= 1'b1;
        blue     <= b;
        green    <= g;
        red      <= r;
        flush    <= fl;
        do @(posedge clk); while (!in_ready);
        beats_sent++;
        model_beat(b, g, r, fl, got, res);
        if (got) pending_px.push_back(typed ? want : res);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_px.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // one whole frame plus its trailing flush beats; style picks the picture content
    task automatic send_frame(input int noise);
        int       w, h, style;
        bit [7:0] b, g, r, lvl;
        pix_res_t none;
        none = '{default: 0};
        w = clamp_size(reg_width);
        h = clamp_size(reg_height);
        style = $urandom_range(2);
        for (int i = 0; i < w * h + 2 * w + 2; i++) begin
            if (i < w * h) begin
                if (style == 0) begin
                    b = 8'($urandom);
                    g = 8'($urandom);
                    r = 8'($urandom);
                end
                else begin
                    lvl = (((i % w) * 3 / w + (i / w) * style) % 2) ? 8'd255 : 8'd0;
                    b = lvl ^ 8'($urandom_range(15));
                    g = lvl;
                    r = lvl ^ 8'($urandom_range(15));
                end
                send_pixel(b, g, r, $urandom_range(99) < noise, 1'b0, none);
            end
            else if ($urandom_range(99) < 4 * noise)
                send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 1'b0, 1'b0, none);
            else
                send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 1'b1, 1'b0, none);
        end
        wait_drained();
    endtask

    // receiver: random stalls plus one long hold-off on request
    initial begin
        int hold_cnt;
        int stall;
        out_ready = 1'b0;
        hold_cnt = 0;
        stall = 0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (out_valid && out_ready) begin
                if (pending_px.size() == 0) begin
                    $error("pixel result with nothing expected: row %0d col %0d",
                           out_row, out_col);
                    failed = 1'b1;
                end
                else begin
                    pix_res_t e;
                    e = pending_px.pop_front();
                    if (edge_res !== e.edge_res) begin
                        $error("edge_res: expected %0d, got %0d", e.edge_res, edge_res);
                        failed = 1'b1;
                    end
                    if (out_row !== e.row) begin
                        $error("out_row: expected %0d, got %0d", e.row, out_row);
                        failed = 1'b1;
                    end
                    if (out_col !== e.col) begin
                        $error("out_col: expected %0d, got %0d", e.col, out_col);
                        failed = 1'b1;
                    end
                    if (last_of_frame !== e.last) begin
                        $error("last_of_frame: expected %0d, got %0d", e.last, last_of_frame);
                        failed = 1'b1;
                    end
                end
            end
            if (hold_req) begin
                hold_req = 1'b0;
                hold_cnt = HOLD_LEN;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                out_ready <= 1'b0;
            end
            else if (stall > 0) begin
                stall--;
                out_ready <= 1'b0;
            end
            else begin
                out_ready <= 1'b1;
                if ($urandom_range(99) < 15) stall = gap_len();
            end
        end
    end

    // watchdog on cycles with no beat moving
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG) begin
                $display("canny_edge_pixel_stream regression: fail");
                $finish;
            end
        end
    end

    initial begin
        dir_row_t dir_rows[$];
        int       frames;
        failed     = 1'b0;
        calm       = 1'b0;
        hold_req   = 1'b0;
        beats_sent = 0;
        in_r = 0;
        in_c = 0;
        out_r = 0;
        out_c = 0;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        blue     = '0;
        green    = '0;
        red      = '0;
        flush    = 1'b0;
        cfg_we   = 1'b0;
        cfg_idx  = cedge_pkg::REG_FRAME_WIDTH;
        cfg_data = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single white pixel, zero width clamps to one: no gradient, no edge
        dir_rows = '{
            '{8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0, '{0, 0, 0, 0}},
            '{8'h00, 8'h00, 8'h00, 1'b1, 1'b0, '{0, 0, 0, 0}},
            '{8'h12, 8'h34, 8'h56, 1'b0, 1'b0, '{0, 0, 0, 0}},
            '{8'h00, 8'h00, 8'h00, 1'b1, 1'b0, '{0, 0, 0, 0}},
            '{8'h00, 8'h00, 8'h00, 1'b1, 1'b1, '{0, 0, 0, 1}},
            // 2x2: extreme colors, a flush inside the frame, pixels in the flush region
            '{8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0, '{0, 0, 0, 0}},
            '{8'h00, 8'h00, 8'h00, 1'b0, 1'b0, '{0, 0, 0, 0}},
            '{8'hFF, 8'h00, 8'hFF, 1'b1, 1'b0, '{0, 0, 0, 0}},
            '{8'h00, 8'hFF, 8'h00, 1'b0, 1'b0, '{0, 0, 0, 0}},
            '{8'hAA, 8'h55, 8'hAA, 1'b0, 1'b0, '{0, 0, 0, 0}},
            '{8'h00, 8'h00, 8'h00, 1'b1, 1'b0, '{0, 0, 0, 0}},
            '{8'h55, 8'hAA, 8'h55, 1'b0, 1'b0, '{0, 0, 0, 0}},
            '{8'h00, 8'h00, 8'h00, 1'b1, 1'b0, '{0, 0, 0, 0}},
            '{8'h00, 8'h00, 8'h00, 1'b1, 1'b0, '{0, 0, 0, 0}},
            '{8'h00, 8'h00, 8'h00, 1'b1, 1'b0, '{0, 0, 0, 0}}
        };
        write_reg(cedge_pkg::REG_FRAME_WIDTH, 0);
        write_reg(cedge_pkg::REG_FRAME_HEIGHT, 1);
        foreach (dir_rows[i]) begin
            if (i == 5) begin
                wait_drained();
                write_reg(cedge_pkg::REG_FRAME_WIDTH, 2);
                write_reg(cedge_pkg::REG_FRAME_HEIGHT, 2);
                write_reg(cedge_pkg::REG_STRONG_LEVEL, 0);
            end
            send_pixel(dir_rows[i].b, dir_rows[i].g, dir_rows[i].r, dir_rows[i].fl,
                       dir_rows[i].typed, dir_rows[i].want);
        end
        wait_drained();

        // tallest frame, a height above the maximum saturates
        write_reg(cedge_pkg::REG_STRONG_LEVEL, 170);
        write_reg(cedge_pkg::REG_FRAME_WIDTH, 1);
        write_reg(cedge_pkg::REG_FRAME_HEIGHT, 2047);
        calm = 1'b1;
        send_frame(2);
        calm = 1'b0;

        frames = 0;
        while (beats_sent < 1900) begin
            write_reg(cedge_pkg::REG_FRAME_WIDTH,
                      ($urandom_range(9) < 8) ? $urandom_range(1, 8) : $urandom_range(3, 40));
            write_reg(cedge_pkg::REG_FRAME_HEIGHT, $urandom_range(1, 6));
            case ($urandom_range(5))
                0: begin
                    write_reg(cedge_pkg::REG_STRONG_LEVEL, 0);
                    write_reg(cedge_pkg::REG_WEAK_LEVEL, 2047);
                end
                1: begin
                    write_reg(cedge_pkg::REG_STRONG_LEVEL, 2047);
                    write_reg(cedge_pkg::REG_WEAK_LEVEL, 0);
                end
                2: begin
                    write_reg(cedge_pkg::REG_STRONG_LEVEL, $urandom_range(2047));
                    write_reg(cedge_pkg::REG_WEAK_LEVEL, $urandom_range(2047));
                end
                default: begin
                    write_reg(cedge_pkg::REG_STRONG_LEVEL, $urandom_range(100, 700));
                    write_reg(cedge_pkg::REG_WEAK_LEVEL, $urandom_range(20, 300));
                end
            endcase
            calm = (frames % 7 == 3);
            if (frames == 4) begin
                write_reg(cedge_pkg::REG_FRAME_WIDTH, 12);
                write_reg(cedge_pkg::REG_FRAME_HEIGHT, 6);
                hold_req = 1'b1;
            end
            send_frame((frames % 4 == 0) ? 10 : 2);
            frames++;
        end

        in_valid <= 1'b0;
        while (pending_px.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (!failed && pending_px.size() == 0)
            $display("canny_edge_pixel_stream regression: pass");
        else
            $display("canny_edge_pixel_stream regression: fail");
        $finish;
    end

endmodule
